// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in every cycle.
`define SIL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SIL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SIL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg
// Types and constants of the sorted insert list.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int SIL_DEPTH     = 16;
  localparam int SIL_KEY_WIDTH = 32;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } sil_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } sil_status_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] item_value;
    logic [INDEX_W-1:0] index;
  } sil_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  entry_count;
  } sil_rsp_t;

  typedef logic [CAP_W-1:0] sil_cfg_t;

  // Command broadcast along the cell row.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [INDEX_W-1:0] idx;
  } sil_ctrl_t;

endpackage

// File: hw/rtl/sil_chan_if.sv
// ----------------------------------------------------------------------------
// sil_chan_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface sil_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sorted_insert_list_unit.sv
// ----------------------------------------------------------------------------
// sorted_insert_list_unit
// Sorted list of keys held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; every cell compares
// and shifts in the accepting cycle, and the result sits in one output register.
// Reset: list emptied, entry count zero, capacity_limit back to 16.
`include "assert_macros.svh"

module sorted_insert_list_unit import sil_pkg::*; #(
  parameter int DEPTH     = SIL_DEPTH,
  parameter int KEY_WIDTH = SIL_KEY_WIDTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  sil_chan_if.sink   cfg_i,
  sil_chan_if.sink   in_i,
  sil_chan_if.source out_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [CW-1:0]    count_q, count_d;
  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q;
  sil_rsp_t         rsp_q, rsp_d;

  logic                 in_fire;
  logic                 full;
  logic                 range_err;
  sil_ctrl_t            ctrl;
  logic [KEY_WIDTH+VALUE_W-1:0] key_x;
  logic [KEY_WIDTH-1:0] new_key;

  logic [KEY_WIDTH-1:0] key_w [DEPTH];
  logic [KEY_WIDTH-1:0] rd_w  [DEPTH];
  logic [DEPTH-1:0]     lt_w;
  logic [DEPTH-1:0]     hit_w;
  logic [IW-1:0]        pos;
  logic [KEY_WIDTH-1:0] rd;

  logic [CW+CAP_W-1:0]         cnt_x, cap_x, dep_x;
  logic [CW+INDEX_W-1:0]       idx_c, cnt_c;
  logic [IW+POS_W-1:0]         pos_x;
  logic [KEY_WIDTH+VALUE_W-1:0] rd_x;
  logic [CW+COUNT_W-1:0]       cnt_o;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;

  assign key_x   = {{KEY_WIDTH{1'b0}}, in_i.data.item_value};
  assign new_key = key_x[KEY_WIDTH-1:0];

  assign cnt_x = {{CAP_W{1'b0}}, count_q};
  assign cap_x = {{CW{1'b0}}, cap_q};
  assign dep_x = (CW + CAP_W)'(DEPTH);
  assign full  = (cnt_x >= cap_x) || (cnt_x >= dep_x);

  assign idx_c     = {{CW{1'b0}}, in_i.data.index};
  assign cnt_c     = {{INDEX_W{1'b0}}, count_q};
  assign range_err = (idx_c >= cnt_c) || (int'(in_i.data.index) >= DEPTH);

  always_comb begin
    ctrl.ins = in_fire && (in_i.data.operation == OP_INSERT) && !full;
    ctrl.rem = in_fire && (in_i.data.operation == OP_REMOVE) && !range_err;
    ctrl.idx = in_i.data.index;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key, right_key;
    logic                 left_lt;
    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = key_w[i-1];
      assign left_lt  = lt_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_body
      assign right_key = key_w[i+1];
    end

    sil_cell #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH),
      .CELL      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_key_i   (new_key),
      .count_i     (count_q),
      .left_key_i  (left_key),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .key_o       (key_w[i]),
      .lt_o        (lt_w[i]),
      .hit_o       (hit_w[i]),
      .rd_o        (rd_w[i])
    );
  end

  always_comb begin
    pos = '0;
    rd  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_w[i]) begin
        pos = pos | IW'(i);
      end
      rd = rd | rd_w[i];
    end
  end

  assign pos_x = {{POS_W{1'b0}}, pos};
  assign rd_x  = {{VALUE_W{1'b0}}, rd};

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CW'(1);
    end
  end

  assign cnt_o = {{COUNT_W{1'b0}}, count_d};

  always_comb begin
    rsp_d             = '0;
    rsp_d.status      = ST_OK;
    rsp_d.entry_count = cnt_o[COUNT_W-1:0];
    unique case (in_i.data.operation)
      OP_INSERT: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.position = pos_x[POS_W-1:0];
        end
      end
      OP_LOOKUP: begin
        if (range_err) begin
          rsp_d.status = ST_RANGE;
        end else begin
          rsp_d.read_value = rd_x[VALUE_W-1:0];
        end
      end
      OP_REMOVE: begin
        if (range_err) begin
          rsp_d.status = ST_RANGE;
        end
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_i.valid && cfg_i.ready) begin
        cap_q <= cfg_i.data;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = rsp_q;

  `SIL_ASSERT(a_count_bound, int'(count_q) <= DEPTH, "entry count above depth")
  `SIL_ASSERT_IMP(a_one_slot, ctrl.ins, $onehot(hit_w), "insert slot not unique")
  `SIL_ASSERT_NXT(a_ins_count, ctrl.ins, count_q == $past(count_q) + CW'(1), "insert count")
  `SIL_ASSERT_NXT(a_rsp_valid, in_fire, out_valid_q, "accepted item gave no result")

endmodule

// File: hw/rtl/sil_cell.sv
// ----------------------------------------------------------------------------
// sil_cell
// One list slot: compares its key with the new key and shifts with neighbors.
// ----------------------------------------------------------------------------
module sil_cell import sil_pkg::*; #(
  parameter int DEPTH     = SIL_DEPTH,
  parameter int KEY_WIDTH = SIL_KEY_WIDTH,
  parameter int CELL      = 0,
  localparam int CW       = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  sil_ctrl_t            ctrl_i,
  input  logic [KEY_WIDTH-1:0] new_key_i,
  input  logic [CW-1:0]        count_i,
  input  logic [KEY_WIDTH-1:0] left_key_i,
  input  logic                 left_lt_i,
  input  logic [KEY_WIDTH-1:0] right_key_i,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic                 lt_o,
  output logic                 hit_o,
  output logic [KEY_WIDTH-1:0] rd_o
);

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 valid;

  assign valid = CW'(CELL) < count_i;
  assign lt_o  = valid && (key_q < new_key_i);
  assign hit_o = !lt_o && left_lt_i;
  assign key_o = key_q;
  assign rd_o  = (CELL == int'(ctrl_i.idx)) ? key_q : '0;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins) begin
      if (!lt_o) begin
        key_d = hit_o ? new_key_i : left_key_i;
      end
    end else if (ctrl_i.rem) begin
      if (CELL >= int'(ctrl_i.idx)) begin
        key_d = right_key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
